// File: design/mmln_pkg.sv
package mmln_pkg;

	// default sample width and result width
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int LEVEL_BITS      = 8;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

	// operation codes carried on the op field
	localparam logic OP_MEASURE   = 1'b0;
	localparam logic OP_NORMALIZE = 1'b1;

	// divider sequencer states
	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_HOLD
	} div_state_t;

endpackage

// File: design/min_max_level_normalizer.sv
// Min-max level normalizer. A measure transaction (op 0) folds a signed sample into a
// running minimum and maximum in the cycle it is accepted and gives no result; start_req
// on it first puts the range back to max 0, min largest value. A normalize transaction
// (op 1) returns floor((sample - min) * 255 / (max - min)) clamped to 0..255, or level 0
// with flat set when max is not above min. Normalize runs through a radix-2 divider that
// forms one quotient bit per cycle: operands load at the accepting edge, the 8-bit quotient
// is formed in DIV_RUN, and the result is written to the output register from DIV_HOLD.
// in_stall stays high until that write, so a new normalize item waits until the last one
// is written out; measure items go one per cycle while the divider is idle. A finished
// result that waits on out_stall holds the divider until the output register frees up.
module min_max_level_normalizer #(
	parameter int SAMPLE_BITS = mmln_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             op,
	input  logic signed [SAMPLE_BITS-1:0]    sample,
	input  logic                             start_req,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [mmln_pkg::LEVEL_BITS-1:0]  level,
	output logic                             flat
);
	import mmln_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LARGEST = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	logic signed [SAMPLE_BITS-1:0] rmax_q, rmin_q;
	logic signed [SAMPLE_BITS-1:0] base_max, base_min;
	logic                          in_accept;
	logic                          div_busy;

	assign in_stall  = div_busy;
	assign in_accept = in_valid && !in_stall;

	// range base after an optional restart
	always_comb begin
		base_max = start_req ? '0 : rmax_q;
		base_min = start_req ? SAMPLE_LARGEST : rmin_q;
	end

	// fold measured samples into the range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmax_q <= '0;
			rmin_q <= SAMPLE_LARGEST;
		end else if (in_accept && op == OP_MEASURE) begin
			rmax_q <= (sample > base_max) ? sample : base_max;
			rmin_q <= (sample < base_min) ? sample : base_min;
		end
	end

	// normalize path
	mmln_div #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_accept && op == OP_NORMALIZE),
		.sample    (sample),
		.rmin      (rmin_q),
		.rmax      (rmax_q),
		.busy      (div_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.level     (level),
		.flat      (flat)
	);

endmodule

// File: design/mmln_div.sv
module mmln_div #(
	parameter int SAMPLE_BITS = mmln_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic signed [SAMPLE_BITS-1:0]     rmin,
	input  logic signed [SAMPLE_BITS-1:0]     rmax,
	output logic                              busy,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mmln_pkg::LEVEL_BITS-1:0]   level,
	output logic                              flat
);
	import mmln_pkg::*;

	localparam int DW  = SAMPLE_BITS + 1;
	localparam int NW  = DW + LEVEL_BITS;
	localparam int CW  = $clog2(LEVEL_BITS);
	localparam logic [CW-1:0] CNT_LAST = CW'(LEVEL_BITS - 1);

	div_state_t state_q, state_d;

	logic signed [DW-1:0]  num_d, den_d;
	logic [NW-1:0]         prod_d;
	logic                  flat_d, fix_d;
	logic [LEVEL_BITS-1:0] fix_level_d;

	logic [DW-1:0]         den_q, rem_q;
	logic [LEVEL_BITS-1:0] low_q, quo_q, fix_level_q;
	logic                  flat_q, fix_q;
	logic [CW-1:0]         cnt_q;
	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic                  flat_out_q;

	logic [DW:0]           trial;
	logic                  qbit;
	logic [DW-1:0]         rem_next;
	logic                  out_free;

	// operand setup: offsets from the range minimum
	always_comb begin
		num_d  = DW'($signed(sample)) - DW'($signed(rmin));
		den_d  = DW'($signed(rmax)) - DW'($signed(rmin));
		flat_d = (rmax <= rmin);
		// num * 255 as (num << 8) - num, only used when 0 < num < den
		prod_d = {num_d, {LEVEL_BITS{1'b0}}} - NW'(unsigned'(num_d));
		fix_d       = 1'b1;
		fix_level_d = '0;
		if (flat_d || num_d <= 0) begin
			fix_d       = 1'b1;
			fix_level_d = '0;
		end else if (num_d >= den_d) begin
			fix_d       = 1'b1;
			fix_level_d = LEVEL_MAX;
		end else begin
			fix_d       = 1'b0;
			fix_level_d = '0;
		end
	end

	// one restoring quotient bit per cycle in DIV_RUN
	always_comb begin
		trial    = {rem_q, low_q[LEVEL_BITS-1]};
		qbit     = (trial >= {1'b0, den_q});
		rem_next = qbit ? DW'(trial - {1'b0, den_q}) : DW'(trial);
	end

	assign out_free = !out_valid_q || !out_stall;

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DIV_IDLE: begin
				if (start) state_d = DIV_RUN;
			end
			DIV_RUN: begin
				if (cnt_q == CNT_LAST) state_d = DIV_HOLD;
			end
			DIV_HOLD: begin
				if (out_free) state_d = DIV_IDLE;
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			den_q       <= den_d;
			rem_q       <= prod_d[NW-1:LEVEL_BITS];
			low_q       <= prod_d[LEVEL_BITS-1:0];
			quo_q       <= '0;
			flat_q      <= flat_d;
			fix_q       <= fix_d;
			fix_level_q <= fix_level_d;
			cnt_q       <= '0;
		end else if (state_q == DIV_RUN) begin
			rem_q <= rem_next;
			low_q <= {low_q[LEVEL_BITS-2:0], 1'b0};
			quo_q <= {quo_q[LEVEL_BITS-2:0], qbit};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == DIV_HOLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_HOLD && out_free) begin
			level_q    <= fix_q ? fix_level_q : quo_q;
			flat_out_q <= flat_q;
		end
	end

	assign busy      = (state_q != DIV_IDLE);
	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign flat      = flat_out_q;

endmodule
